// File: rtl/sitoa_pkg.sv
// Shared constants, control struct and digit-count helper for the
// signed integer to decimal ASCII converter. No dependencies.
package sitoa_pkg;

  localparam int VALUE_WIDTH = 32;

  // Decimal digits needed for the largest magnitude, 2^(VALUE_WIDTH-1).
  function automatic int digit_count(input int w);
    longint unsigned v;
    int n;
    v = 64'd1 << (w - 1);
    n = 0;
    do begin
      v = v / 10;
      n++;
    end while (v != 0);
    return n;
  endfunction

  localparam int NUM_DIGITS = digit_count(VALUE_WIDTH);
  localparam int DIGIT_BITS = NUM_DIGITS * 4;
  localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);
  localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);

  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;

  typedef struct packed {
    logic load;       // take a new magnitude, clear the BCD digits
    logic step;       // one shift-and-add-3 iteration
    logic shift_out;  // drop the top digit, move the rest up
  } sitoa_ctl_t;

endpackage

// File: rtl/sitoa_bcd.sv
// Binary to BCD converter (shift-and-add-3), one input bit per step, and
// a digit shifter that presents the most significant digit. Uses sitoa_pkg.
module sitoa_bcd
  import sitoa_pkg::*;
(
  input  logic                   clk,
  input  sitoa_ctl_t             ctl,
  input  logic [VALUE_WIDTH-1:0] mag_in,
  output logic [3:0]             top_digit
);

  logic [DIGIT_BITS-1:0]  bcd;
  logic [DIGIT_BITS-1:0]  bcd_adj;
  logic [VALUE_WIDTH-1:0] mag;

  // Add 3 to every digit of 5 or more before the shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  // Hold both registers when no control line is set.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      bcd <= '0;
      mag <= mag_in;
    end else if (ctl.step) begin
      bcd <= {bcd_adj[DIGIT_BITS-2:0], mag[VALUE_WIDTH-1]};
      mag <= {mag[VALUE_WIDTH-2:0], 1'b0};
    end else if (ctl.shift_out) begin
      bcd <= {bcd[DIGIT_BITS-5:0], 4'd0};
    end
  end

  assign top_digit = bcd[DIGIT_BITS-1 -: 4];

endmodule

// File: rtl/signed_int_to_decimal_ascii_core.sv
// Signed integer to decimal ASCII text: top level with the sequencer.
// Uses sitoa_pkg and the sitoa_bcd converter.
//
// One value is taken at a time. After a beat is accepted, the magnitude is
// converted to BCD by a shift-and-add-3 unit, one bit per cycle, for
// VALUE_WIDTH bits (32). Leading zero digits are then dropped at one digit
// per cycle, after which the text goes out one character per cycle while
// char_ready is high: '-' for a negative value, then the digits, with last
// on the final one. value_ready is high only while the block is idle.
module signed_int_to_decimal_ascii_core
  import sitoa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic [VALUE_WIDTH-1:0] value,
  input  logic                   value_valid,
  output logic                   value_ready,
  output logic [7:0]             character,
  output logic                   last,
  output logic                   char_valid,
  input  logic                   char_ready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_SIGN,
    S_DIGIT
  } state_t;

  state_t             state;
  logic               negative;
  logic [CNT_W-1:0]   bitcnt;
  logic [LEFT_W-1:0]  left;
  logic [3:0]         top_digit;
  logic [VALUE_WIDTH-1:0] mag_in;
  logic               skip_zero;
  sitoa_ctl_t         ctl;

  // Unsigned negation, so the most negative value keeps its full magnitude.
  assign mag_in = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;

  assign skip_zero = (top_digit == 4'd0) && (left > LEFT_W'(1));

  assign value_ready = (state == S_IDLE);
  assign char_valid  = (state == S_SIGN) || (state == S_DIGIT);
  assign character   = (state == S_SIGN) ? CHAR_MINUS : (CHAR_ZERO + {4'd0, top_digit});
  assign last        = (state == S_DIGIT) && (left == LEFT_W'(1));

  always_comb begin
    ctl.load      = (state == S_IDLE) && value_valid;
    ctl.step      = (state == S_CONV);
    ctl.shift_out = ((state == S_SKIP) && skip_zero) ||
                    ((state == S_DIGIT) && char_ready && (left != LEFT_W'(1)));
  end

  sitoa_bcd u_bcd (
    .clk       (clk),
    .ctl       (ctl),
    .mag_in    (mag_in),
    .top_digit (top_digit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      negative <= 1'b0;
      bitcnt   <= '0;
      left     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (value_valid) begin
            negative <= value[VALUE_WIDTH-1];
            bitcnt   <= CNT_W'(VALUE_WIDTH);
            state    <= S_CONV;
          end
        end
        S_CONV: begin
          bitcnt <= bitcnt - 1'b1;
          if (bitcnt == CNT_W'(1)) begin
            left  <= LEFT_W'(NUM_DIGITS);
            state <= S_SKIP;
          end
        end
        S_SKIP: begin
          // Drop leading zeros, keep at least one digit.
          if (skip_zero) begin
            left <= left - 1'b1;
          end else begin
            state <= negative ? S_SIGN : S_DIGIT;
          end
        end
        S_SIGN: begin
          if (char_ready) begin
            state <= S_DIGIT;
          end
        end
        S_DIGIT: begin
          if (char_ready) begin
            if (left == LEFT_W'(1)) begin
              state <= S_IDLE;
            end else begin
              left <= left - 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(value_ready && char_valid))
    else $error("input accepted while text still pending");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIGIT) |-> (top_digit <= 4'd9))
    else $error("BCD digit out of range");

  a_accept_conv: assert property (@(posedge clk) disable iff (rst)
    (value_valid && value_ready) |=> (state == S_CONV))
    else $error("accepted beat did not start conversion");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (char_valid && char_ready && last) |=> value_ready)
    else $error("not idle after final character");

  a_skip_left: assert property (@(posedge clk) disable iff (rst)
    (state == S_SKIP || state == S_DIGIT) |-> (left != '0))
    else $error("digit count underflow");

endmodule
